@@ design/srfp_pkg.sv @@
// srfp_pkg: shared widths, constants, types and the palette table for the
// sound reactive flash pulse unit. No dependencies.
package srfp_pkg;

    localparam int VOL_W       = 10;
    localparam int HIST_DEPTH  = 20;
    localparam int SUM_W       = 15;
    localparam int LEVEL_W     = 5;
    localparam int NUM_LEVELS  = 20;
    localparam int COLOR_W     = 4;
    localparam int NUM_COLORS  = 12;
    localparam int CH_W        = 8;
    localparam int THR_W       = 5;
    localparam int CFG_DATA_W  = 10;

    localparam logic [VOL_W-1:0] FLOOR_RESET = 10'd550;
    localparam logic [THR_W-1:0] THR_RESET   = 5'd10;

    // 1.15 * sum / 19 compared exactly as 380 * vol against 23 * sum
    localparam int CMP_W       = 20;
    localparam int AVG_VOL_MUL = 380;
    localparam int AVG_SUM_MUL = 23;

    // x / 10 for x below 1029 as (x * 205) >> 11
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int Q_W         = 7;

    // floor(c * 7 / 10) as (c * 7 * 3277) >> 15
    localparam int DECAY_MUL   = 22939;
    localparam int DECAY_SHIFT = 15;

    typedef enum logic [0:0] {
        CFG_VOLUME_FLOOR   = 1'b0,
        CFG_JUMP_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // per-frame data handed from the front stage to the flash stage
    typedef struct packed {
        logic [VOL_W-1:0]        vol;
        logic signed [VOL_W:0]   diff;
        logic                    above;
        logic                    below;
    } front_t;

    function automatic rgb_t palette_color(input logic [COLOR_W-1:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:    c = '{red: 8'd120, green: 8'd0,   blue: 8'd0};
            4'd1:    c = '{red: 8'd90,  green: 8'd30,  blue: 8'd0};
            4'd2:    c = '{red: 8'd60,  green: 8'd60,  blue: 8'd0};
            4'd3:    c = '{red: 8'd30,  green: 8'd90,  blue: 8'd0};
            4'd4:    c = '{red: 8'd0,   green: 8'd120, blue: 8'd0};
            4'd5:    c = '{red: 8'd0,   green: 8'd90,  blue: 8'd30};
            4'd6:    c = '{red: 8'd0,   green: 8'd60,  blue: 8'd60};
            4'd7:    c = '{red: 8'd0,   green: 8'd30,  blue: 8'd90};
            4'd8:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd120};
            4'd9:    c = '{red: 8'd30,  green: 8'd0,   blue: 8'd90};
            4'd10:   c = '{red: 8'd60,  green: 8'd0,   blue: 8'd60};
            4'd11:   c = '{red: 8'd90,  green: 8'd0,   blue: 8'd30};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ design/srfp_hist_cell.sv @@
// srfp_hist_cell: one cell of the volume history chain, holds one past
// frame volume and passes it to its neighbor on each frame. Uses srfp_pkg.
module srfp_hist_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic [srfp_pkg::VOL_W-1:0] d_in,
    output logic [srfp_pkg::VOL_W-1:0] q_out
);
    import srfp_pkg::*;

    logic [VOL_W-1:0] vol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg <= '0;
        end else if (shift_en) begin
            vol_reg <= d_in;
        end
    end

    assign q_out = vol_reg;

endmodule

@@ design/srfp_flash_stage.sv @@
// srfp_flash_stage: level smoothing, palette advance, flash hysteresis and
// channel decay; also the result register. Uses srfp_pkg.
module srfp_flash_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  srfp_pkg::front_t             front,
    input  logic [srfp_pkg::THR_W-1:0]   jump_thr,
    output logic                         out_valid,
    input  logic                         out_ready,
    output srfp_pkg::rgb_t               strip,
    output logic                         flashed,
    output logic [srfp_pkg::LEVEL_W-1:0] level,
    output logic [srfp_pkg::COLOR_W-1:0] color,
    output logic [srfp_pkg::VOL_W-1:0]   volume
);
    import srfp_pkg::*;

    localparam int PROD_W = VOL_W + 8;
    localparam int DEC_W  = CH_W + DECAY_SHIFT;
    localparam logic signed [Q_W+1:0] MAX_LEVEL = (Q_W+2)'(NUM_LEVELS);

    function automatic logic [CH_W-1:0] decay(input logic [CH_W-1:0] c);
        logic [DEC_W-1:0] p;
        p = DEC_W'(c) * DEC_W'(DECAY_MUL);
        return p[DECAY_SHIFT +: CH_W];
    endfunction

    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                exceeded_reg, exceeded_next;
    rgb_t                strip_reg, strip_next;
    logic                flashed_reg, flashed_next;
    logic [VOL_W-1:0]    volume_reg;

    logic                take;
    logic [VOL_W:0]      neg_diff;
    logic [VOL_W-1:0]    mag;
    logic [PROD_W-1:0]   prod;
    logic [Q_W-1:0]      quot;
    logic signed [Q_W:0]   raw;
    logic signed [Q_W+1:0] raw_ext, level_ext, rise, lvl_cand, thr_ext;
    logic                jump;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // raw level: (vol - floor) / 10 truncated toward zero
    always_comb begin
        neg_diff = -front.diff;
        mag      = front.diff[VOL_W] ? neg_diff[VOL_W-1:0] : front.diff[VOL_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(DIV10_MUL);
        quot     = prod[DIV10_SHIFT +: Q_W];
        raw      = front.diff[VOL_W] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_comb begin
        raw_ext   = (Q_W+2)'(raw);
        level_ext = $signed((Q_W+2)'(level_reg));
        thr_ext   = $signed((Q_W+2)'(jump_thr));
        rise      = raw_ext - level_ext;
        jump      = rise > thr_ext;

        lvl_cand = (raw_ext > level_ext) ? raw_ext : level_ext - (Q_W+2)'(1);
        if (lvl_cand[Q_W+1]) begin
            level_next = '0;
        end else if (lvl_cand > MAX_LEVEL) begin
            level_next = LEVEL_W'(NUM_LEVELS);
        end else begin
            level_next = lvl_cand[LEVEL_W-1:0];
        end

        if (!jump) begin
            color_next = color_reg;
        end else if (color_reg == COLOR_W'(NUM_COLORS - 1)) begin
            color_next = '0;
        end else begin
            color_next = color_reg + COLOR_W'(1);
        end
    end

    // flash on first crossing, otherwise decay
    always_comb begin
        if (front.above && !exceeded_reg) begin
            exceeded_next = 1'b1;
            flashed_next  = 1'b1;
            strip_next    = palette_color(color_next);
        end else begin
            exceeded_next = front.below ? 1'b0 : exceeded_reg;
            flashed_next  = 1'b0;
            strip_next    = '{red:   decay(strip_reg.red),
                              green: decay(strip_reg.green),
                              blue:  decay(strip_reg.blue)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            color_reg     <= '0;
            exceeded_reg  <= 1'b0;
            strip_reg     <= '0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (take) begin
                level_reg    <= level_next;
                color_reg    <= color_next;
                exceeded_reg <= exceeded_next;
                strip_reg    <= strip_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            flashed_reg <= flashed_next;
            volume_reg  <= front.vol;
        end
    end

    assign out_valid = out_valid_reg;
    assign strip     = strip_reg;
    assign flashed   = flashed_reg;
    assign level     = level_reg;
    assign color     = color_reg;
    assign volume    = volume_reg;

endmodule

@@ design/sound_reactive_flash_pulse_unit.sv @@
// sound_reactive_flash_pulse_unit: top level with peak tracker, volume history
// chain, window sum and flash stage; uses srfp_pkg, srfp_hist_cell, srfp_flash_stage.
// One sample transaction per cycle while s_ready; a frame-end sample's result passes
// the front register, then the result register. A held result blocks input once the
// front register is also full. Synchronous reset (aresetn low) clears all state but
// front data, flashed flag and frame volume; loads volume floor 550, jump threshold 10.
module sound_reactive_flash_pulse_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [srfp_pkg::VOL_W-1:0]      s_sample,
    input  logic                            s_frame_end,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [srfp_pkg::CH_W-1:0]       m_red,
    output logic [srfp_pkg::CH_W-1:0]       m_green,
    output logic [srfp_pkg::CH_W-1:0]       m_blue,
    output logic                            m_flashed,
    output logic [srfp_pkg::LEVEL_W-1:0]    m_sound_level,
    output logic [srfp_pkg::COLOR_W-1:0]    m_palette_index,
    output logic [srfp_pkg::VOL_W-1:0]      m_frame_volume,
    // config write port
    input  logic                            cfg_we,
    input  srfp_pkg::cfg_index_t            cfg_index,
    input  logic [srfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import srfp_pkg::*;

    // config registers
    logic [VOL_W-1:0] floor_reg;
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
            thr_reg   <= THR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_VOLUME_FLOOR:   floor_reg <= cfg_wdata[VOL_W-1:0];
                CFG_JUMP_THRESHOLD: thr_reg   <= cfg_wdata[THR_W-1:0];
            endcase
        end
    end

    // handshake: the front register frees up whenever the flash stage can take it
    logic   s_accept, frame_accept;
    logic   front_valid_reg;
    front_t front_reg, front_next;
    logic   stage_ready;

    assign s_ready      = !front_valid_reg || stage_ready;
    assign s_accept     = s_valid && s_ready;
    assign frame_accept = s_accept && s_frame_end;

    // peak of the current frame; the frame-end sample itself counts
    logic [VOL_W-1:0] peak_reg;
    logic [VOL_W-1:0] frame_peak;

    assign frame_peak = (s_sample > peak_reg) ? s_sample : peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
        end else if (s_accept) begin
            peak_reg <= s_frame_end ? '0 : frame_peak;
        end
    end

    // volume history: a row of cells, newest volume enters cell 0 each frame
    logic [VOL_W-1:0] hist_q [HIST_DEPTH];

    for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_hist
        logic [VOL_W-1:0] cell_in;
        if (i == 0) begin : g_head
            assign cell_in = frame_peak;
        end else begin : g_link
            assign cell_in = hist_q[i-1];
        end
        srfp_hist_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (frame_accept),
            .d_in     (cell_in),
            .q_out    (hist_q[i])
        );
    end

    // running sum of the older entries (cells 1 .. last), before the shift
    logic [SUM_W-1:0] window_sum_reg, window_sum_next;
    logic [SUM_W:0]   sum_wide;

    assign sum_wide = {1'b0, window_sum_reg}
                    + (SUM_W+1)'(hist_q[0])
                    - (SUM_W+1)'(hist_q[HIST_DEPTH-1]);
    assign window_sum_next = sum_wide[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sum_reg <= '0;
        end else if (frame_accept) begin
            window_sum_reg <= window_sum_next;
        end
    end

    // threshold compare against 1.15 times the average, in exact integers
    logic [CMP_W-1:0] vol_scaled, sum_scaled;

    assign vol_scaled = CMP_W'(frame_peak) * CMP_W'(AVG_VOL_MUL);
    assign sum_scaled = CMP_W'(window_sum_reg) * CMP_W'(AVG_SUM_MUL);

    always_comb begin
        front_next.vol   = frame_peak;
        front_next.diff  = $signed({1'b0, frame_peak}) - $signed({1'b0, floor_reg});
        front_next.above = vol_scaled > sum_scaled;
        front_next.below = vol_scaled < sum_scaled;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= frame_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_accept) begin
            front_reg <= front_next;
        end
    end

    // level, palette and flash decision; holds the result register
    rgb_t strip;

    srfp_flash_stage u_flash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid_reg),
        .in_ready  (stage_ready),
        .front     (front_reg),
        .jump_thr  (thr_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .strip     (strip),
        .flashed   (m_flashed),
        .level     (m_sound_level),
        .color     (m_palette_index),
        .volume    (m_frame_volume)
    );

    assign m_red   = strip.red;
    assign m_green = strip.green;
    assign m_blue  = strip.blue;

    // checks
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        window_sum_reg <= SUM_W'((HIST_DEPTH - 1) * ((1 << VOL_W) - 1)))
        else $error("window sum out of range");

    a_frame_to_front: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_accept |=> front_valid_reg)
        else $error("frame-end transaction lost before flash stage");

    a_flash_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_flashed) |-> (strip == palette_color(m_palette_index)))
        else $error("flash color differs from palette entry");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sound_level <= LEVEL_W'(NUM_LEVELS)
                     && m_palette_index < COLOR_W'(NUM_COLORS)))
        else $error("level or palette index out of range");

endmodule
